// ===== rtl/gire_pkg.sv =====
// Shared types, constants and reaction tables of the Gillespie immune reaction step unit.
// Used by the datapath, the controller and the top level; depends on nothing.
package gire_pkg;

	localparam int          NUM_COUNTS  = 10;
	localparam int          NUM_REACT   = 21;
	localparam logic [4:0]  NO_REACTION = 5'd21;
	localparam logic [4:0]  LAST_REACT  = 5'd20;
	localparam logic [4:0]  REACT_SAT   = 5'd1;   // virus saturation term, from the divider
	localparam logic [4:0]  REACT_ACT   = 5'd3;   // presenter activation, scaled by 2^-56
	localparam logic [3:0]  NO_COUNT    = 4'd15;
	localparam logic [5:0]  LAST_SQUARE = 6'd47;
	localparam logic [5:0]  MANT_TOP    = 6'd62;

	localparam logic [58:0] PROP_CAP = '1;
	localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AB;

	localparam logic [63:0] LIM_PRESENTER = 64'd1000000;
	localparam logic [63:0] LIM_HELPER    = 64'd1000000;
	localparam logic [63:0] LIM_KILLER    = 64'd500000;
	localparam logic [63:0] LIM_BCELL     = 64'd250000;

	// Fixed rate coefficients, 48 fraction bits.
	localparam logic [59:0] Q_ONE       = 60'd281474976710656;
	localparam logic [59:0] Q_ALPHA_AP  = 60'd703687441777;
	localparam logic [59:0] Q_ACT_AP    = 60'd123848989752689;
	localparam logic [59:0] Q_M_APM     = 60'd151433537470333;
	localparam logic [59:0] Q_ALPHA_THN = 60'd61080069946;
	localparam logic [59:0] Q_BETA_THN  = 60'd28147498;
	localparam logic [59:0] Q_R_T       = 60'd2814750;
	localparam logic [59:0] Q_M_THE     = 60'd61924494876344;
	localparam logic [59:0] Q_PV_TKE    = 60'd441915713436;
	localparam logic [59:0] Q_R2_B      = 60'd3574732;
	localparam logic [59:0] Q_ALPHA_B   = 60'd1688849860263936;
	localparam logic [59:0] Q_BETA_PS   = 60'd189151184350;
	localparam logic [59:0] Q_M_PS      = 60'd562949953421312;
	localparam logic [59:0] Q_PI_AS     = 60'd562949953421;
	localparam logic [59:0] Q_M_A       = 60'd11258999068426;

	// Configuration register indexes and their reset values.
	localparam logic [1:0]  CFG_SUPPLY     = 2'd0;
	localparam logic [1:0]  CFG_ACTIVATION = 2'd1;
	localparam logic [1:0]  CFG_NEUTRALIZE = 2'd2;
	localparam logic [1:0]  CFG_DEATH      = 2'd3;
	localparam logic [59:0] RST_SUPPLY     = 60'd610800699462;
	localparam logic [59:0] RST_ACTIVATION = 60'd28147497671;
	localparam logic [59:0] RST_NEUTRALIZE = 60'd1370783137;
	localparam logic [59:0] RST_DEATH      = 60'd168884986026394;

	typedef enum logic [2:0] {MS_XY, MS_COEF, MS_DT, MS_SQ, MS_LN2} mul_sel_t;
	typedef enum logic [1:0] {DS_SAT, DS_RATIO, DS_WAIT} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_SAT_GO, ST_SAT_WT, ST_RAT_GO, ST_RAT_WT,
		ST_XY_GO, ST_XY_WT, ST_CF_GO, ST_CF_WT, ST_TOT, ST_DT_WT, ST_SEL,
		ST_APPLY, ST_NORM, ST_SQ_GO, ST_SQ_WT, ST_LN_GO, ST_LN_WT,
		ST_WT_GO, ST_WT_WT, ST_OUT
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       load_wr;
		logic       mul_go;
		mul_sel_t   mul_sel;
		logic       div_go;
		div_sel_t   div_sel;
		logic       sat_st;
		logic       ratio_st;
		logic       xy_st;
		logic       prop_st;
		logic       dt_st;
		logic       sel_st;
		logic       apply;
		logic       norm;
		logic       sq_st;
		logic       ln_st;
		logic       wait_st;
		logic       wait_ones;
		logic       out_ld;
		logic [4:0] k;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic total_zero;
		logic hit;
		logic wdraw_zero;
		logic normed;
		logic is_load;
	} stat_t;

	// Count raised by each reaction.
	function automatic logic [3:0] rise_of(input logic [4:0] r);
		logic [3:0] v;
		unique case (r)
			5'd0:          v = 4'd0;
			5'd2:          v = 4'd1;
			5'd3:          v = 4'd2;
			5'd5:          v = 4'd3;
			5'd6, 5'd7:    v = 4'd4;
			5'd9:          v = 4'd5;
			5'd10, 5'd11:  v = 4'd6;
			5'd14, 5'd15:  v = 4'd7;
			5'd16:         v = 4'd8;
			5'd18:         v = 4'd9;
			default:       v = NO_COUNT;
		endcase
		return v;
	endfunction

	// Count lowered by each reaction.
	function automatic logic [3:0] fall_of(input logic [4:0] r);
		logic [3:0] v;
		unique case (r)
			5'd1, 5'd13, 5'd20: v = 4'd0;
			5'd3:               v = 4'd1;
			5'd4:               v = 4'd2;
			5'd6:               v = 4'd3;
			5'd8:               v = 4'd4;
			5'd10:              v = 4'd5;
			5'd12:              v = 4'd6;
			5'd16:              v = 4'd7;
			5'd17:              v = 4'd8;
			5'd19:              v = 4'd9;
			default:            v = NO_COUNT;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/gire_mul.sv =====
// Iterative 64 x 64 multiplier, one 32 x 32 partial product per cycle.
// Depends on nothing; used by the datapath for all products of a step.
module gire_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod,
	output logic         done
);
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [1:0]   sh;
	logic [127:0] term;

	assign a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp     = 64'(a_part) * 64'(b_part);
	assign sh     = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	assign term   = 128'(pp) << {sh, 5'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule

// ===== rtl/gire_div.sv =====
// Restoring 128 / 64 divider, one quotient bit per cycle, saturating on overflow.
// Depends on nothing; used by the datapath for the two ratios and the waiting time.
module gire_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] nh,
	input  logic [63:0] nl,
	input  logic [63:0] d,
	output logic [63:0] q,
	output logic        done
);
	logic [63:0] rem_q, nl_q, q_q, d_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [63:0] rem2;
	logic        take;

	assign rem2 = {rem_q[62:0], nl_q[63]};
	assign take = rem_q[63] || (rem2 >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= '0;
				if (nh >= d) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= nh;
			nl_q  <= nl;
			d_q   <= d;
			q_q   <= (nh >= d) ? '1 : '0;
		end else if (busy_q) begin
			nl_q  <= {nl_q[62:0], 1'b0};
			rem_q <= take ? rem2 - d_q : rem2;
			q_q   <= {q_q[62:0], take};
		end
	end

	assign q    = q_q;
	assign done = done_q;
endmodule

// ===== rtl/gire_dp.sv =====
// Datapath of the step unit: counts, rate registers, propensity store, selection and log.
// Depends on gire_pkg, gire_mul and gire_div; driven by commands from gire_ctrl.
module gire_dp
	import gire_pkg::*;
#(
	parameter int CW = 24,
	parameter int DW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [59:0]            cfg_wdata,
	input  logic                   in_op,
	input  logic [3:0]             in_sel,
	input  logic [CW-1:0]          in_val,
	input  logic [DW-1:0]          in_draw,
	input  logic [DW-1:0]          in_wdraw,
	output logic [4:0]             fired_reaction,
	output logic [63:0]            wait_time,
	output logic [NUM_COUNTS*CW-1:0] counts
);
	localparam int DTW = DW + 64;

	logic          op_q;
	logic [3:0]    sel_q;
	logic [CW-1:0] val_q;
	logic [DW-1:0] draw_q, wdraw_q;
	logic [CW-1:0] cnt_q [NUM_COUNTS];
	logic [59:0]   rate_q [4];
	logic [63:0]   ratio_q, xy_q, total_q, cum_q, wait_q, m_q, l_q;
	logic [58:0]   p_q [NUM_REACT];
	logic [DTW-1:0] dt_q;
	logic [4:0]    fired_q;
	logic [5:0]    e_q;
	logic [47:0]   frac_q;

	logic [63:0]   c64 [NUM_COUNTS];
	logic [63:0]   coef, x, y, mul_a, mul_b, div_nh, div_nl, div_d, div_q, n, cum_next, m2;
	logic [127:0]  mul_p, shv;
	logic          mul_done, div_done;
	logic [58:0]   pval, satval;
	logic [3:0]    rise, fall;

	function automatic logic [63:0] headroom(input logic [63:0] lim, input logic [63:0] c);
		return (c < lim) ? lim - c : 64'd0;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_COUNTS; i++) begin
			c64[i] = 64'(cnt_q[i]);
		end
	end

	// Operands of each reaction's propensity but the saturation term: coef * x * y.
	always_comb begin
		coef = '0;
		x    = '0;
		y    = 64'd1;
		unique case (cmd.k)
			5'd0:  begin coef = 64'(Q_ONE);       x = c64[0]; end
			5'd2:  begin coef = 64'(Q_ALPHA_AP);  x = headroom(LIM_PRESENTER, c64[1]); end
			5'd3:  begin coef = 64'(Q_ACT_AP);    x = c64[1]; y = ratio_q; end
			5'd4:  begin coef = 64'(Q_M_APM);     x = c64[2]; end
			5'd5:  begin coef = 64'(Q_ALPHA_THN); x = headroom(LIM_HELPER, c64[3]); end
			5'd6:  begin coef = 64'(Q_BETA_THN);  x = c64[2]; y = c64[3]; end
			5'd7:  begin coef = 64'(Q_R_T);       x = c64[2]; y = c64[4]; end
			5'd8:  begin coef = 64'(Q_M_THE);     x = c64[4]; end
			5'd9:  begin coef = 64'(rate_q[0]);   x = headroom(LIM_KILLER, c64[5]); end
			5'd10: begin coef = 64'(rate_q[1]);   x = c64[2]; y = c64[5]; end
			5'd11: begin coef = 64'(Q_R_T);       x = c64[2]; y = c64[6]; end
			5'd12: begin coef = 64'(rate_q[3]);   x = c64[6]; end
			5'd13: begin coef = 64'(Q_PV_TKE);    x = c64[0]; y = c64[6]; end
			5'd14: begin coef = 64'(Q_R2_B);      x = c64[4]; y = c64[7]; end
			5'd15: begin coef = 64'(Q_ALPHA_B);   x = headroom(LIM_BCELL, c64[7]); end
			5'd16: begin coef = 64'(Q_BETA_PS);   x = c64[2]; y = c64[7]; end
			5'd17: begin coef = 64'(Q_M_PS);      x = c64[8]; end
			5'd18: begin coef = 64'(Q_PI_AS);     x = c64[8]; end
			5'd19: begin coef = 64'(Q_M_A);       x = c64[9]; end
			5'd20: begin coef = 64'(rate_q[2]);   x = c64[0]; y = c64[9]; end
			default: ;
		endcase
	end

	assign n = (64'(DW) << 48) - ((64'(e_q) << 48) | 64'(frac_q));

	always_comb begin
		unique case (cmd.mul_sel)
			MS_XY:   begin mul_a = x;              mul_b = y;       end
			MS_COEF: begin mul_a = coef;           mul_b = xy_q;    end
			MS_DT:   begin mul_a = 64'(draw_q);    mul_b = total_q; end
			MS_SQ:   begin mul_a = m_q;            mul_b = m_q;     end
			MS_LN2:  begin mul_a = n;              mul_b = LN2_Q64; end
			default: begin mul_a = '0;             mul_b = '0;      end
		endcase
	end

	always_comb begin
		unique case (cmd.div_sel)
			DS_SAT: begin
				div_nh = '0;
				div_nl = ((c64[0] << 2) + c64[0]) << 24;
				div_d  = 64'd5 + (c64[0] << 1) + c64[0];
			end
			DS_RATIO: begin
				div_nh = '0;
				div_nl = c64[0] << 32;
				div_d  = 64'd40 + c64[0];
			end
			DS_WAIT: begin
				div_nh = l_q >> 40;
				div_nl = l_q << 24;
				div_d  = total_q;
			end
			default: begin
				div_nh = '0;
				div_nl = '0;
				div_d  = 64'd1;
			end
		endcase
	end

	gire_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_p),
		.done   (mul_done)
	);

	gire_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.nh     (div_nh),
		.nl     (div_nl),
		.d      (div_d),
		.q      (div_q),
		.done   (div_done)
	);

	// Propensity scaling: 2^-56 for presenter activation, 2^-24 otherwise, then capped.
	assign shv      = (cmd.k == REACT_ACT) ? (mul_p >> 56) : (mul_p >> 24);
	assign pval     = (|shv[127:59]) ? PROP_CAP : shv[58:0];
	assign satval   = (|div_q[63:59]) ? PROP_CAP : div_q[58:0];
	assign cum_next = cum_q + 64'(p_q[cmd.k]);
	assign m2       = mul_p[125:62];
	assign rise     = rise_of(fired_q);
	assign fall     = fall_of(fired_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTS; i++) begin
				cnt_q[i] <= '0;
			end
			rate_q[0] <= RST_SUPPLY;
			rate_q[1] <= RST_ACTIVATION;
			rate_q[2] <= RST_NEUTRALIZE;
			rate_q[3] <= RST_DEATH;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_SUPPLY:     rate_q[0] <= cfg_wdata;
					CFG_ACTIVATION: rate_q[1] <= cfg_wdata;
					CFG_NEUTRALIZE: rate_q[2] <= cfg_wdata;
					CFG_DEATH:      rate_q[3] <= cfg_wdata;
					default: ;
				endcase
			end
			for (int i = 0; i < NUM_COUNTS; i++) begin
				if (cmd.load_wr && sel_q == 4'(i)) begin
					cnt_q[i] <= val_q;
				end else if (cmd.apply) begin
					if (rise == 4'(i) && cnt_q[i] != '1) begin
						cnt_q[i] <= cnt_q[i] + CW'(1);
					end else if (fall == 4'(i) && cnt_q[i] != '0) begin
						cnt_q[i] <= cnt_q[i] - CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_op;
			sel_q   <= in_sel;
			val_q   <= in_val;
			draw_q  <= in_draw;
			wdraw_q <= in_wdraw;
			total_q <= '0;
			cum_q   <= '0;
			fired_q <= NO_REACTION;
			wait_q  <= '0;
		end
		if (cmd.sat_st) begin
			p_q[REACT_SAT] <= satval;
			total_q        <= total_q + 64'(satval);
		end
		if (cmd.ratio_st) begin
			ratio_q <= div_q;
		end
		if (cmd.xy_st) begin
			xy_q <= mul_p[63:0];
		end
		if (cmd.prop_st) begin
			p_q[cmd.k] <= pval;
			total_q    <= total_q + 64'(pval);
		end
		if (cmd.dt_st) begin
			dt_q <= mul_p[DTW-1:0];
		end
		if (cmd.sel_st) begin
			cum_q <= cum_next;
			if (stat.hit) begin
				fired_q <= cmd.k;
			end
		end
		if (cmd.apply) begin
			m_q <= 64'(wdraw_q);
			e_q <= MANT_TOP;
		end
		if (cmd.norm) begin
			m_q <= {m_q[62:0], 1'b0};
			e_q <= e_q - 6'd1;
		end
		if (cmd.sq_st) begin
			frac_q <= {frac_q[46:0], m2[63]};
			m_q    <= m2[63] ? (m2 >> 1) : m2;
		end
		if (cmd.ln_st) begin
			l_q <= mul_p[127:64];
		end
		if (cmd.wait_st) begin
			wait_q <= div_q;
		end
		if (cmd.wait_ones) begin
			wait_q <= '1;
		end
	end

	always_comb begin
		stat.mul_done   = mul_done;
		stat.div_done   = div_done;
		stat.total_zero = (total_q == '0);
		stat.hit        = (dt_q < {cum_next, {DW{1'b0}}});
		stat.wdraw_zero = (wdraw_q == '0);
		stat.normed     = m_q[62];
		stat.is_load    = op_q;
	end

	always_comb begin
		for (int i = 0; i < NUM_COUNTS; i++) begin
			counts[i*CW +: CW] = cnt_q[i];
		end
	end

	assign fired_reaction = fired_q;
	assign wait_time      = wait_q;
endmodule

// ===== rtl/gire_ctrl.sv =====
// Controller of the step unit: sequences divisions, products, selection and logarithm.
// Depends on gire_pkg; drives gire_dp with commands and reads its status.
module gire_ctrl
	import gire_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_xfer,
	input  logic  out_free,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  idle
);
	state_t     state_q, state_d;
	logic [4:0] k_q, k_d;
	logic [5:0] j_q, j_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		j_d         = j_q;
		cmd         = '0;
		cmd.mul_sel = MS_XY;
		cmd.div_sel = DS_SAT;
		cmd.k       = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISP;
				end
			end
			ST_DISP: begin
				if (stat.is_load) begin
					cmd.load_wr = 1'b1;
					state_d     = ST_OUT;
				end else begin
					state_d = ST_SAT_GO;
				end
			end
			ST_SAT_GO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_SAT;
				state_d     = ST_SAT_WT;
			end
			ST_SAT_WT: begin
				cmd.div_sel = DS_SAT;
				if (stat.div_done) begin
					cmd.sat_st = 1'b1;
					state_d    = ST_RAT_GO;
				end
			end
			ST_RAT_GO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_RATIO;
				state_d     = ST_RAT_WT;
			end
			ST_RAT_WT: begin
				cmd.div_sel = DS_RATIO;
				if (stat.div_done) begin
					cmd.ratio_st = 1'b1;
					k_d          = '0;
					state_d      = ST_XY_GO;
				end
			end
			ST_XY_GO: begin
				if (k_q == REACT_SAT) begin
					k_d = k_q + 5'd1;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = MS_XY;
					state_d     = ST_XY_WT;
				end
			end
			ST_XY_WT: begin
				if (stat.mul_done) begin
					cmd.xy_st = 1'b1;
					state_d   = ST_CF_GO;
				end
			end
			ST_CF_GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_COEF;
				state_d     = ST_CF_WT;
			end
			ST_CF_WT: begin
				cmd.mul_sel = MS_COEF;
				if (stat.mul_done) begin
					cmd.prop_st = 1'b1;
					if (k_q == LAST_REACT) begin
						state_d = ST_TOT;
					end else begin
						k_d     = k_q + 5'd1;
						state_d = ST_XY_GO;
					end
				end
			end
			ST_TOT: begin
				if (stat.total_zero) begin
					cmd.wait_ones = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = MS_DT;
					state_d     = ST_DT_WT;
				end
			end
			ST_DT_WT: begin
				cmd.mul_sel = MS_DT;
				if (stat.mul_done) begin
					cmd.dt_st = 1'b1;
					k_d       = '0;
					state_d   = ST_SEL;
				end
			end
			ST_SEL: begin
				cmd.sel_st = 1'b1;
				if (stat.hit) begin
					state_d = ST_APPLY;
				end else begin
					k_d = k_q + 5'd1;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (stat.wdraw_zero) begin
					cmd.wait_ones = 1'b1;
					state_d       = ST_OUT;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (stat.normed) begin
					j_d     = '0;
					state_d = ST_SQ_GO;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			ST_SQ_GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_SQ;
				state_d     = ST_SQ_WT;
			end
			ST_SQ_WT: begin
				cmd.mul_sel = MS_SQ;
				if (stat.mul_done) begin
					cmd.sq_st = 1'b1;
					if (j_q == LAST_SQUARE) begin
						state_d = ST_LN_GO;
					end else begin
						j_d     = j_q + 6'd1;
						state_d = ST_SQ_GO;
					end
				end
			end
			ST_LN_GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_LN2;
				state_d     = ST_LN_WT;
			end
			ST_LN_WT: begin
				cmd.mul_sel = MS_LN2;
				if (stat.mul_done) begin
					cmd.ln_st = 1'b1;
					state_d   = ST_WT_GO;
				end
			end
			ST_WT_GO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_WAIT;
				state_d     = ST_WT_WT;
			end
			ST_WT_WT: begin
				cmd.div_sel = DS_WAIT;
				if (stat.div_done) begin
					cmd.wait_st = 1'b1;
					state_d     = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign idle = (state_q == ST_IDLE);
endmodule

// ===== rtl/gillespie_immune_reaction_step_unit.sv =====
// Top level of the Gillespie immune reaction step unit: stream ports and output register.
// Depends on gire_pkg, gire_ctrl and gire_dp.
//
// This block performs one direct-method stochastic step of a fixed network of 21
// reactions among ten population counts, or loads one count, for each transfer on the
// input stream, and returns exactly one result transfer with the fired reaction, the
// waiting time (Q16.48, saturating) and all ten counts after the step. The host supplies
// both uniform draws. Items are handled one at a time. A load latches the item, writes
// the count in the dispatch state and then waits to load the result. Three divisions use
// the bit-serial divider: virus saturation, the presenter ratio and the final waiting
// time. Each of the 20 computed propensities takes two products, and the logarithm takes
// 48 squarings. All products share the single 32 x 32 multiply unit, which builds each
// 64 x 64 product from 32 x 32 partial products. The reaction search examines reactions
// in index order until the running sum passes the scaled select draw. The mantissa
// normalization shifts the wait draw until its leading one reaches bit 62. A step
// whose propensities sum to zero, or whose wait draw is zero, returns an all-ones
// waiting time. A waiting time that overflows makes the last division saturate
// without iterating. The result sits in an output register, so the next input
// transfer is taken while a result still waits; a new result is written only after
// the previous one has been taken. The four rate registers may be written at any
// edge with cfg_we high while no item is in flight; indexes follow their reset list.
module gillespie_immune_reaction_step_unit
	import gire_pkg::*;
#(
	parameter int COUNT_WIDTH = 24,
	parameter int DRAW_WIDTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [59:0]         cfg_wdata,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	// tdata, lowest bit up: count_value, select_draw, wait_draw, zero fill.
	input  logic [((COUNT_WIDTH+2*DRAW_WIDTH+7)/8)*8-1:0] s_tdata,
	// tuser, lowest bit up: op, count_select.
	input  logic [4:0]          s_tuser,
	// Output stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	// tdata, lowest bit up: fired_reaction, wait_time, virus_count, presenter_count,
	// mature_presenter_count, naive_helper_count, effector_helper_count,
	// naive_killer_count, effector_killer_count, bcell_count, plasma_count,
	// antibody_count, zero fill.
	output logic [((NUM_COUNTS*COUNT_WIDTH+69+7)/8)*8-1:0] m_tdata
);
	localparam int OUT_W = ((NUM_COUNTS*COUNT_WIDTH+69+7)/8)*8;

	cmd_t  cmd;
	stat_t stat;
	logic  idle;
	logic  in_xfer, out_free;
	logic  m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [4:0]  fired;
	logic [63:0] wait_t;
	logic [NUM_COUNTS*COUNT_WIDTH-1:0] counts;

	// The block is ready for a new item whenever the controller is idle.
	assign s_tready = idle;
	assign in_xfer  = s_tvalid && s_tready;
	// The output register may be loaded when it is empty or emptied at this edge.
	assign out_free = !m_tvalid_q || m_tready;

	gire_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_xfer  (in_xfer),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle)
	);

	gire_dp #(
		.CW (COUNT_WIDTH),
		.DW (DRAW_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_op          (s_tuser[0]),
		.in_sel         (s_tuser[4:1]),
		.in_val         (s_tdata[COUNT_WIDTH-1:0]),
		.in_draw        (s_tdata[COUNT_WIDTH+DRAW_WIDTH-1:COUNT_WIDTH]),
		.in_wdraw       (s_tdata[COUNT_WIDTH+2*DRAW_WIDTH-1:COUNT_WIDTH+DRAW_WIDTH]),
		.fired_reaction (fired),
		.wait_time      (wait_t),
		.counts         (counts)
	);

	// Output register: holds a finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_tdata_q <= OUT_W'({counts, wait_t, fired});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Once an item is taken the controller must be busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input accepted while the previous item was still being taken");

	// A reported reaction is always a valid index or the no-reaction code.
	a_fired_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] <= NO_REACTION))
		else $error("fired reaction index out of range");

	// A result is loaded only into an empty or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("result overwrote one not yet transferred");
endmodule
